[design/ofrq_pkg.sv]
// Package: shared types and constants for the optical flow rate qualifier.
`timescale 1ns / 1ps
package ofrq_pkg;

    localparam logic [7:0]  QUALITY_HIGH_RST = 8'd35;
    localparam logic [7:0]  QUALITY_LOW_RST  = 8'd10;
    localparam logic [31:0] TIMEOUT_RST      = 32'd100000;
    localparam logic [15:0] SCALE_RST        = 16'd2688;
    localparam logic [24:0] DEG2RAD_Q30      = 25'd18740330;
    localparam logic [27:0] FLOW_GAIN        = 28'd256000000;
    localparam int          DIV_W            = 64;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_QHIGH = 2'd0,
        REG_QLOW  = 2'd1,
        REG_TMO   = 2'd2,
        REG_SCALE = 2'd3
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GYRO,
        ST_POLL,
        ST_LOAD,
        ST_DIV,
        ST_MUL,
        ST_STORE,
        ST_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       gyro_acc;     // integrate gyro sample
        logic       poll_update;  // health, hysteresis, quality on poll
        logic       load;         // load divider for channel sel
        logic       div_step;     // one divider iteration
        logic       mul;          // convert quotient to rad
        logic       store;        // store rate for channel sel
        logic       finish;       // clear accumulators / timeout clear
        logic       out_load;     // load output register
        logic [1:0] sel;          // 0 flow x, 1 flow y, 2 body x, 3 body y
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_gyro;
        logic div_done;
    } sts_t;

endpackage

[design/ofrq_ctrl.sv]
// Controller: sequences integration, the four divisions and result delivery.
`timescale 1ns / 1ps
module ofrq_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          out_stall,
    output logic          out_valid,
    input  ofrq_pkg::sts_t sts,
    output ofrq_pkg::cmd_t cmd
);
    import ofrq_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] sel_reg, sel_next;
    logic       out_valid_reg, out_valid_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sel_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    // a result may wait in the output register while the next item is taken
    assign in_stall  = (state_reg != ST_IDLE);

    // next state
    always_comb
    begin
        state_next = state_reg;
        sel_next   = sel_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = sts.is_gyro ? ST_GYRO : ST_POLL;
            ST_GYRO:
                state_next = ST_IDLE;
            ST_POLL:
            begin
                sel_next   = 2'd0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
                state_next = ST_DIV;
            ST_DIV:
                if (sts.div_done)
                    state_next = ST_MUL;
            ST_MUL:
                state_next = ST_STORE;
            ST_STORE:
            begin
                sel_next = sel_reg + 2'd1;
                if (sel_reg == 2'd3)
                    state_next = ST_OUT;
                else
                    state_next = ST_LOAD;
            end
            ST_OUT:
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
            out_valid_next = 1'b1;
    end

    // commands
    always_comb
    begin
        cmd             = '0;
        cmd.sel         = sel_reg;
        unique case (state_reg)
            ST_GYRO:  cmd.gyro_acc    = 1'b1;
            ST_POLL:  cmd.poll_update = 1'b1;
            ST_LOAD:  cmd.load        = 1'b1;
            ST_DIV:   cmd.div_step    = 1'b1;
            ST_MUL:   cmd.mul         = 1'b1;
            ST_STORE:
            begin
                cmd.store  = 1'b1;
                cmd.finish = (sel_reg == 2'd3);
            end
            ST_OUT:   cmd.out_load = (!out_valid_reg || !out_stall);
            default:  cmd = cmd;
        endcase
    end

endmodule

[design/ofrq_dp.sv]
// Datapath: accumulators, hysteresis, shared restoring divider and rad conversion.
`timescale 1ns / 1ps
module ofrq_dp (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_take,
    input  logic                 func,
    input  logic signed [15:0]   gyro_rate_x,
    input  logic signed [15:0]   gyro_rate_y,
    input  logic        [15:0]   gyro_delta_us,
    input  logic        [31:0]   now_us,
    input  logic                 new_data,
    input  logic        [7:0]    quality,
    input  logic signed [15:0]   flow_raw_x,
    input  logic signed [15:0]   flow_raw_y,
    input  logic        [19:0]   sensor_dt_us,
    input  logic        [7:0]    quality_high,
    input  logic        [7:0]    quality_low,
    input  logic        [31:0]   timeout_us,
    input  logic        [15:0]   flow_scale_q8,
    input  ofrq_pkg::cmd_t       cmd,
    output ofrq_pkg::sts_t       sts,
    output logic signed [31:0]   flow_rate_x,
    output logic signed [31:0]   flow_rate_y,
    output logic signed [31:0]   body_rate_x,
    output logic signed [31:0]   body_rate_y,
    output logic                 flow_valid,
    output logic                 healthy,
    output logic        [7:0]    last_quality
);
    import ofrq_pkg::*;

    // captured item
    logic               func_reg;
    logic signed [15:0] grx_reg, gry_reg, frx_reg, fry_reg;
    logic [15:0]        gdt_reg;
    logic [31:0]        now_reg;
    logic               nd_reg;
    logic [7:0]         q_reg;
    logic [19:0]        dt_reg;

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            func_reg <= func;
            grx_reg  <= gyro_rate_x;
            gry_reg  <= gyro_rate_y;
            gdt_reg  <= gyro_delta_us;
            now_reg  <= now_us;
            nd_reg   <= new_data;
            q_reg    <= quality;
            frx_reg  <= flow_raw_x;
            fry_reg  <= flow_raw_y;
            dt_reg   <= sensor_dt_us;
        end
    end

    assign sts.is_gyro = !func;

    // state
    logic        healthy_reg, valid_reg;
    logic [31:0] last_t_reg;
    logic [7:0]  hq_reg;
    logic [47:0] acc_x_reg, acc_y_reg;
    logic [31:0] tacc_reg;
    logic [31:0] rate_reg [4];
    logic        timeout_hit_reg;   // poll without data timed out
    logic        ndata_reg;         // poll carried data

    logic [47:0] prod_x, prod_y;
    assign prod_x = 48'($signed(grx_reg) * $signed({1'b0, gdt_reg}));
    assign prod_y = 48'($signed(gry_reg) * $signed({1'b0, gdt_reg}));

    logic        valid_new;
    always_comb
    begin
        valid_new = valid_reg;
        if (!valid_reg)
        begin
            if (q_reg >= quality_high)
                valid_new = 1'b1;
        end
        else if (q_reg <= quality_low)
            valid_new = 1'b0;
    end

    // divider
    logic [DIV_W-1:0] num_reg, quo_reg;
    logic [47:0]      den_reg;
    logic [48:0]      rem_reg;
    logic [6:0]       cnt_reg;
    logic             neg_reg, zero_reg;
    logic [32:0]      r_reg;

    logic [48:0] rem_sh;
    logic [49:0] rem_sub;
    assign rem_sh  = {rem_reg[47:0], num_reg[DIV_W-1]};
    assign rem_sub = {1'b0, rem_sh} - {2'b0, den_reg};
    assign sts.div_done = (cnt_reg == 7'd0);

    // operand selection for one channel
    logic [47:0] acc_sel, acc_mag;
    logic        acc_neg;
    logic [15:0] raw_sel, raw_mag;
    logic        raw_neg;
    logic [35:0] den_flow;
    logic [43:0] raw_gain;
    always_comb
    begin
        acc_sel  = cmd.sel[0] ? acc_y_reg : acc_x_reg;
        acc_neg  = acc_sel[47];
        acc_mag  = acc_neg ? (48'd0 - acc_sel) : acc_sel;
        raw_sel  = cmd.sel[0] ? fry_reg : frx_reg;
        raw_neg  = raw_sel[15];
        raw_mag  = raw_neg ? (16'd0 - raw_sel) : raw_sel;
        den_flow = 36'(dt_reg) * 36'(flow_scale_q8);
        raw_gain = 44'(raw_mag) * 44'(FLOW_GAIN);
    end

    // conversion: quotient split as in hi/lo parts
    logic [43:0] mhi;
    logic [44:0] mlo;
    logic [44:0] sum;
    always_comb
    begin
        mhi = 44'(quo_reg[36:20]) * 44'(DEG2RAD_Q30);
        mlo = 45'(quo_reg[19:0]) * 45'(DEG2RAD_Q30);
        sum = 45'(mhi) + 45'(mlo[44:20]);
    end

    logic [31:0] rate_fin;
    always_comb
    begin
        if (zero_reg)
            rate_fin = 32'd0;
        else if (neg_reg)
            rate_fin = (r_reg > 33'h80000000) ? 32'h80000000 : 32'(33'd0 - r_reg);
        else
            rate_fin = (r_reg > 33'h7FFFFFFF) ? 32'h7FFFFFFF : r_reg[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            healthy_reg     <= 1'b0;
            valid_reg       <= 1'b0;
            last_t_reg      <= 32'd0;
            hq_reg          <= 8'd0;
            acc_x_reg       <= 48'd0;
            acc_y_reg       <= 48'd0;
            tacc_reg        <= 32'd0;
            for (int i = 0; i < 4; i++)
                rate_reg[i] <= 32'd0;
            timeout_hit_reg <= 1'b0;
            ndata_reg       <= 1'b0;
            cnt_reg         <= 7'd0;
        end
        else
        begin
            // gyro integration
            if (cmd.gyro_acc && healthy_reg)
            begin
                acc_x_reg <= acc_x_reg + prod_x;
                acc_y_reg <= acc_y_reg + prod_y;
                tacc_reg  <= tacc_reg + 32'(gdt_reg);
            end
            // poll bookkeeping
            if (cmd.poll_update)
            begin
                ndata_reg       <= nd_reg;
                timeout_hit_reg <= 1'b0;
                if (nd_reg)
                begin
                    healthy_reg <= 1'b1;
                    last_t_reg  <= now_reg;
                    hq_reg      <= q_reg;
                    valid_reg   <= valid_new;
                end
                else if (healthy_reg && ((now_reg - last_t_reg) > timeout_us))
                begin
                    timeout_hit_reg <= 1'b1;
                    healthy_reg     <= 1'b0;
                    valid_reg       <= 1'b0;
                    hq_reg          <= 8'd0;
                end
            end
            if (cmd.load)
                cnt_reg <= 7'(DIV_W);
            else if (cmd.div_step && cnt_reg != 7'd0)
                cnt_reg <= cnt_reg - 7'd1;
            if (cmd.store && (ndata_reg || timeout_hit_reg))
                rate_reg[cmd.sel] <= rate_fin;
            if (cmd.finish && (ndata_reg || timeout_hit_reg))
            begin
                acc_x_reg <= 48'd0;
                acc_y_reg <= 48'd0;
                tacc_reg  <= 32'd0;
            end
        end
    end

    // divider operands and iterations
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= 49'd0;
            quo_reg <= '0;
            if (cmd.sel[1])
            begin
                num_reg  <= 64'({acc_mag, 12'd0});
                den_reg  <= 48'(tacc_reg);
                neg_reg  <= acc_neg;
                zero_reg <= !ndata_reg || (tacc_reg == 32'd0);
            end
            else
            begin
                num_reg  <= {4'd0, raw_gain, 16'd0};
                den_reg  <= 48'(den_flow);
                neg_reg  <= raw_neg;
                zero_reg <= !ndata_reg || !valid_reg || (flow_scale_q8 <= 16'd2)
                            || (dt_reg == 20'd0);
            end
        end
        else if (cmd.div_step && cnt_reg != 7'd0)
        begin
            num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            if (!rem_sub[49])
            begin
                rem_reg <= rem_sub[48:0];
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
            end
        end
        // quotient of 2^37 or more saturates the conversion
        if (cmd.mul)
            r_reg <= (quo_reg[DIV_W-1:37] != '0) ? 33'h100000000 : 33'(sum >> 10);
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            flow_rate_x  <= rate_reg[0];
            flow_rate_y  <= rate_reg[1];
            body_rate_x  <= rate_reg[2];
            body_rate_y  <= rate_reg[3];
            flow_valid   <= valid_reg;
            healthy      <= healthy_reg;
            last_quality <= hq_reg;
        end
    end

endmodule

[design/optical_flow_rate_qualifier_unit.sv]
// Top level: optical flow rate qualifier with configuration registers.
//
// Usage:
//   One input channel (in_valid / in_stall) carries gyro samples (func 0) and
//   flow polls (func 1). A gyro sample gives no result. A flow poll gives
//   one result on the output channel (out_valid / out_stall) after it is
//   taken: an update step, then per rate a load, divide, convert and store
//   step, as the four rates share one restoring divider that retires one
//   quotient bit per cycle (64 bits), then the output step. After the output
//   step the block returns to idle and can take the next item.
//   Items are taken one at a time; a finished result waits in the output
//   register while the next item is accepted. If the receiver stalls, the
//   result holds and a following poll waits at its output step.
//   Configuration writes (cfg_valid / cfg_ready, index cfg_index) are always
//   ready; the user must make them while the block is idle (unenforced).
//   Reset clears health, validity, quality, accumulators and held rates
//   and loads the register defaults (35, 10, 100000, 2688).
`timescale 1ns / 1ps
module optical_flow_rate_qualifier_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic signed [15:0] gyro_rate_x,
    input  logic signed [15:0] gyro_rate_y,
    input  logic        [15:0] gyro_delta_us,
    input  logic        [31:0] now_us,
    input  logic               new_data,
    input  logic        [7:0]  quality,
    input  logic signed [15:0] flow_raw_x,
    input  logic signed [15:0] flow_raw_y,
    input  logic        [19:0] sensor_dt_us,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] flow_rate_x,
    output logic signed [31:0] flow_rate_y,
    output logic signed [31:0] body_rate_x,
    output logic signed [31:0] body_rate_y,
    output logic               flow_valid,
    output logic               healthy,
    output logic        [7:0]  last_quality,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic        [1:0]  cfg_index,
    input  logic        [31:0] cfg_data
);
    import ofrq_pkg::*;

    logic [7:0]  qhigh_reg, qlow_reg;
    logic [31:0] tmo_reg;
    logic [15:0] scale_reg;
    cmd_t        cmd;
    sts_t        sts;
    logic        in_take;

    assign cfg_ready = 1'b1;
    assign in_take   = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qhigh_reg <= QUALITY_HIGH_RST;
            qlow_reg  <= QUALITY_LOW_RST;
            tmo_reg   <= TIMEOUT_RST;
            scale_reg <= SCALE_RST;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_QHIGH: qhigh_reg <= cfg_data[7:0];
                REG_QLOW:  qlow_reg  <= cfg_data[7:0];
                REG_TMO:   tmo_reg   <= cfg_data;
                REG_SCALE: scale_reg <= cfg_data[15:0];
                default:   qhigh_reg <= qhigh_reg;
            endcase
        end
    end

    ofrq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    ofrq_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_take       (in_take),
        .func          (func),
        .gyro_rate_x   (gyro_rate_x),
        .gyro_rate_y   (gyro_rate_y),
        .gyro_delta_us (gyro_delta_us),
        .now_us        (now_us),
        .new_data      (new_data),
        .quality       (quality),
        .flow_raw_x    (flow_raw_x),
        .flow_raw_y    (flow_raw_y),
        .sensor_dt_us  (sensor_dt_us),
        .quality_high  (qhigh_reg),
        .quality_low   (qlow_reg),
        .timeout_us    (tmo_reg),
        .flow_scale_q8 (scale_reg),
        .cmd           (cmd),
        .sts           (sts),
        .flow_rate_x   (flow_rate_x),
        .flow_rate_y   (flow_rate_y),
        .body_rate_x   (body_rate_x),
        .body_rate_y   (body_rate_y),
        .flow_valid    (flow_valid),
        .healthy       (healthy),
        .last_quality  (last_quality)
    );

`ifndef SYNTHESIS
    // no item is taken while one is in work
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_step || cmd.load || cmd.mul) |-> in_stall)
        else $error("input taken during division");
    // a result appears only from the output step
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.out_load))
        else $error("result without output step");
    // accumulators are idle while dividing
    a_no_int: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> !cmd.gyro_acc)
        else $error("integration during division");
`endif

endmodule
